### design/baro_pkg.sv
// ----------------------------------------------------------------------------
// baro_pkg
// Shared types and constants for the barometer compensation core.
// ----------------------------------------------------------------------------
package baro_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        t_REG_AC1_AC2 = 3'd0,
        t_REG_AC3_AC4 = 3'd1,
        t_REG_AC5_AC6 = 3'd2,
        t_REG_B1_B2   = 3'd3,
        t_REG_MC_MD   = 3'd4,
        t_REG_OSS     = 3'd5
    } t_reg_idx;

    localparam logic [17:0] PRESSURE_MAX = 18'h3FFFF;
    localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
    localparam logic signed [31:0] P_C3038   = 32'sd3038;
    localparam logic signed [31:0] P_CM7357  = -32'sd7357;
    localparam logic signed [31:0] P_C3791   = 32'sd3791;
    localparam logic [31:0]        T4_BIAS   = 32'd32768;
    localparam logic [15:0]        B7_SCALE  = 16'd50000;

endpackage

### design/baro_div.sv
// ----------------------------------------------------------------------------
// baro_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Side data travels with each item; the whole pipe holds when i_en is low.
// ----------------------------------------------------------------------------
module baro_div #(
    parameter int NW = 32,
    parameter int DW = 17,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [NW];
    logic [DW-1:0] r_rem  [NW];
    logic [NW-1:0] r_num  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];

    genvar s;
    generate
        for (s = 0; s < NW; s++) begin : g_stage
            logic          p_vld;
            logic [DW-1:0] p_rem;
            logic [NW-1:0] p_num;
            logic [DW-1:0] p_den;
            logic [SW-1:0] p_side;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;

            if (s == 0) begin : g_first
                assign p_vld  = i_vld;
                assign p_rem  = '0;
                assign p_num  = i_num;
                assign p_den  = i_den;
                assign p_side = i_side;
            end else begin : g_next
                assign p_vld  = r_vld[s-1];
                assign p_rem  = r_rem[s-1];
                assign p_num  = r_num[s-1];
                assign p_den  = r_den[s-1];
                assign p_side = r_side[s-1];
            end

            assign trial = {p_rem, p_num[NW-1]};
            assign diff  = trial - {1'b0, p_den};
            assign ge    = (trial >= {1'b0, p_den});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    r_num[s]  <= {p_num[NW-2:0], ge};
                    r_den[s]  <= p_den;
                    r_side[s] <= p_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[NW-1];
    assign o_quo  = r_num[NW-1];
    assign o_side = r_side[NW-1];

endmodule

### design/barometer_compensation_core.sv
// ----------------------------------------------------------------------------
// barometer_compensation_core
// Integer temperature and pressure compensation from factory calibration.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the two dividers (27 and 32 bit stages)
// set the depth. Any output stall holds every stage at once.
// Reset (synchronous, active low) clears all valid bits, the calibration
// registers to zero and the oversampling setting to 3.
module barometer_compensation_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_raw_temperature,
    input  logic [23:0]        i_raw_pressure,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_temperature,
    output logic [17:0]        o_pressure,
    output logic               o_fault
);

    // ------------------------------------------------------------ config
    logic [31:0] r_ac12, r_ac34, r_ac56, r_b12, r_mcmd;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac12 <= '0;
            r_ac34 <= '0;
            r_ac56 <= '0;
            r_b12  <= '0;
            r_mcmd <= '0;
            r_oss  <= 2'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                baro_pkg::t_REG_AC1_AC2: r_ac12 <= i_cfg_data;
                baro_pkg::t_REG_AC3_AC4: r_ac34 <= i_cfg_data;
                baro_pkg::t_REG_AC5_AC6: r_ac56 <= i_cfg_data;
                baro_pkg::t_REG_B1_B2:   r_b12  <= i_cfg_data;
                baro_pkg::t_REG_MC_MD:   r_mcmd <= i_cfg_data;
                baro_pkg::t_REG_OSS:     r_oss  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;
    assign ac1 = r_ac12[31:16];
    assign ac2 = r_ac12[15:0];
    assign ac3 = r_ac34[31:16];
    assign ac4 = r_ac34[15:0];
    assign ac5 = r_ac56[31:16];
    assign ac6 = r_ac56[15:0];
    assign b1  = r_b12[31:16];
    assign b2  = r_b12[15:0];
    assign mc  = r_mcmd[31:16];
    assign md  = r_mcmd[15:0];

    // global advance: every stage moves when the output slot is free
    logic en;
    logic r_o_vld;
    assign en         = !r_o_vld || i_out_ready;
    assign o_in_ready = en;

    // ------------------------------------------------------------ stage A
    logic signed [16:0] a_diff;
    logic signed [33:0] a_mul;
    logic               r_a_v;
    logic signed [31:0] r_a_prod;
    logic [23:0]        r_a_up;

    assign a_diff = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, ac6});
    assign a_mul  = a_diff * $signed({1'b0, ac5});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_prod <= a_mul[31:0];
            r_a_up   <= i_raw_pressure;
        end
    end

    // ------------------------------------------------------------ stage B
    logic signed [31:0] b_x1, b_d, b_num;
    logic               r_b_v;
    logic signed [31:0] r_b_x1;
    logic [26:0]        r_b_nmag;
    logic [31:0]        r_b_dmag;
    logic               r_b_neg, r_b_dz;
    logic [23:0]        r_b_up;

    assign b_x1  = r_a_prod >>> 15;
    assign b_d   = b_x1 + 32'(md);
    assign b_num = {{5{mc[15]}}, mc, 11'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_x1   <= b_x1;
            r_b_nmag <= b_num[31] ? 27'(-b_num) : b_num[26:0];
            r_b_dmag <= b_d[31] ? 32'(-b_d) : b_d;
            r_b_neg  <= b_num[31] ^ b_d[31];
            r_b_dz   <= (b_d == '0);
            r_b_up   <= r_a_up;
        end
    end

    // ------------------------------------------------------------ divider 1
    localparam int S1W = 32 + 1 + 1 + 24;
    logic           d1_vld;
    logic [26:0]    d1_quo;
    logic [S1W-1:0] d1_side;

    baro_div #(.NW(27), .DW(32), .SW(S1W)) u_div_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_b_v),
        .i_num  (r_b_nmag),
        .i_den  (r_b_dmag),
        .i_side ({r_b_x1, r_b_dz, r_b_neg, r_b_up}),
        .o_vld  (d1_vld),
        .o_quo  (d1_quo),
        .o_side (d1_side)
    );

    // ------------------------------------------------------------ stage C
    logic signed [31:0] c_x1, c_q, c_x2;
    logic               c_dz, c_neg;
    logic               r_c_v;
    logic signed [31:0] r_c_b5;
    logic               r_c_flt;
    logic [23:0]        r_c_up;

    assign c_x1  = d1_side[S1W-1 -: 32];
    assign c_dz  = d1_side[25];
    assign c_neg = d1_side[24];
    assign c_q   = c_neg ? -$signed({5'b0, d1_quo}) : $signed({5'b0, d1_quo});
    assign c_x2  = c_dz ? '0 : c_q;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_b5  <= c_x1 + c_x2;
            r_c_flt <= c_dz;
            r_c_up  <= d1_side[23:0];
        end
    end

    // ------------------------------------------------------------ stage D
    logic signed [31:0] d_t8, d_t;
    logic               r_d_v;
    logic signed [15:0] r_d_t;
    logic signed [31:0] r_d_b6;
    logic               r_d_flt;
    logic [23:0]        r_d_up;

    assign d_t8 = r_c_b5 + 32'sd8;
    assign d_t  = d_t8 >>> 4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            priority if (d_t > 32'sd32767)   r_d_t <= 16'sh7FFF;
            else if (d_t < -32'sd32768)      r_d_t <= 16'sh8000;
            else                             r_d_t <= d_t[15:0];
            r_d_b6  <= r_c_b5 - baro_pkg::B6_OFFSET;
            r_d_flt <= r_c_flt;
            r_d_up  <= r_c_up;
        end
    end

    // ------------------------------------------------------------ stage E
    logic               r_e_v;
    logic signed [31:0] r_e_sq, r_e_m2, r_e_m3;
    logic signed [15:0] r_e_t;
    logic               r_e_flt;
    logic [23:0]        r_e_up;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_sq  <= 32'(r_d_b6 * r_d_b6);
            r_e_m2  <= 32'(32'(ac2) * r_d_b6);
            r_e_m3  <= 32'(32'(ac3) * r_d_b6);
            r_e_t   <= r_d_t;
            r_e_flt <= r_d_flt;
            r_e_up  <= r_d_up;
        end
    end

    // ------------------------------------------------------------ stage F
    logic signed [31:0] f_s;
    logic               r_f_v;
    logic signed [31:0] r_f_mb2, r_f_mb1, r_f_m2, r_f_m3;
    logic signed [15:0] r_f_t;
    logic               r_f_flt;
    logic [23:0]        r_f_up;

    assign f_s = r_e_sq >>> 12;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_mb2 <= 32'(32'(b2) * f_s);
            r_f_mb1 <= 32'(32'(b1) * f_s);
            r_f_m2  <= r_e_m2;
            r_f_m3  <= r_e_m3;
            r_f_t   <= r_e_t;
            r_f_flt <= r_e_flt;
            r_f_up  <= r_e_up;
        end
    end

    // ------------------------------------------------------------ stage G
    logic               r_g_v;
    logic signed [31:0] r_g_x3, r_g_y;
    logic signed [15:0] r_g_t;
    logic               r_g_flt;
    logic [23:0]        r_g_up;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_x3  <= (r_f_mb2 >>> 11) + (r_f_m2 >>> 11);
            r_g_y   <= (r_f_m3 >>> 13) + (r_f_mb1 >>> 16) + 32'sd2;
            r_g_t   <= r_f_t;
            r_g_flt <= r_f_flt;
            r_g_up  <= r_f_up;
        end
    end

    // ------------------------------------------------------------ stage H
    logic signed [31:0] h_v, h_w, h_x3b;
    logic               r_h_v;
    logic signed [31:0] r_h_b3;
    logic [31:0]        r_h_t4;
    logic signed [15:0] r_h_t;
    logic               r_h_flt;
    logic [23:0]        r_h_up;

    assign h_v   = {{14{ac1[15]}}, ac1, 2'b0} + r_g_x3;
    assign h_w   = (h_v <<< r_oss) + 32'sd2;
    assign h_x3b = r_g_y >>> 2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // divide by four, truncating toward zero
            r_h_b3  <= (h_w + (h_w[31] ? 32'sd3 : 32'sd0)) >>> 2;
            r_h_t4  <= h_x3b + baro_pkg::T4_BIAS;
            r_h_t   <= r_g_t;
            r_h_flt <= r_g_flt;
            r_h_up  <= r_g_up;
        end
    end

    // ------------------------------------------------------------ stage I
    logic [47:0] i_b4p;
    logic [47:0] i_b7p;
    logic [31:0] i_upd;
    logic [15:0] i_scale;
    logic               r_i_v;
    logic [16:0]        r_i_b4;
    logic [31:0]        r_i_b7;
    logic signed [15:0] r_i_t;
    logic               r_i_flt;

    assign i_scale = baro_pkg::B7_SCALE >> r_oss;
    assign i_upd   = {8'b0, r_h_up} - r_h_b3;
    assign i_b4p   = ac4 * r_h_t4;
    assign i_b7p   = i_upd * i_scale;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_b4  <= i_b4p[31:15];
            r_i_b7  <= i_b7p[31:0];
            r_i_t   <= r_h_t;
            r_i_flt <= r_h_flt;
        end
    end

    // ------------------------------------------------------------ divider 2
    logic        j_big;
    logic [31:0] j_num;
    logic        d2_vld;
    logic [31:0] d2_quo;
    logic [17:0] d2_side;

    assign j_big = r_i_b7[31];
    assign j_num = j_big ? r_i_b7 : {r_i_b7[30:0], 1'b0};

    baro_div #(.NW(32), .DW(17), .SW(18)) u_div_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_i_v),
        .i_num  (j_num),
        .i_den  (r_i_b4),
        .i_side ({r_i_t, r_i_flt || (r_i_b4 == '0), j_big}),
        .o_vld  (d2_vld),
        .o_quo  (d2_quo),
        .o_side (d2_side)
    );

    // ------------------------------------------------------------ stage K
    logic signed [31:0] k_p, k_x1;
    logic               r_k_v;
    logic signed [31:0] r_k_sq, r_k_x2m, r_k_p;
    logic signed [15:0] r_k_t;
    logic               r_k_flt;

    assign k_p  = d2_side[0] ? {d2_quo[30:0], 1'b0} : d2_quo;
    assign k_x1 = k_p >>> 8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k_sq  <= 32'(k_x1 * k_x1);
            r_k_x2m <= 32'(baro_pkg::P_CM7357 * k_p);
            r_k_p   <= k_p;
            r_k_t   <= d2_side[17:2];
            r_k_flt <= d2_side[1];
        end
    end

    // ------------------------------------------------------------ stage L
    logic               r_l_v;
    logic signed [31:0] r_l_m, r_l_x2m, r_l_p;
    logic signed [15:0] r_l_t;
    logic               r_l_flt;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l_m   <= 32'(r_k_sq * baro_pkg::P_C3038);
            r_l_x2m <= r_k_x2m;
            r_l_p   <= r_k_p;
            r_l_t   <= r_k_t;
            r_l_flt <= r_k_flt;
        end
    end

    // ------------------------------------------------------------ stage M
    logic               r_m_v;
    logic signed [31:0] r_m_sum, r_m_p;
    logic signed [15:0] r_m_t;
    logic               r_m_flt;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_sum <= (r_l_m >>> 16) + (r_l_x2m >>> 16) + baro_pkg::P_C3791;
            r_m_p   <= r_l_p;
            r_m_t   <= r_l_t;
            r_m_flt <= r_l_flt;
        end
    end

    // ------------------------------------------------------------ output
    logic signed [31:0] n_pf;
    logic signed [15:0] r_o_t;
    logic [17:0]        r_o_p;
    logic               r_o_flt;

    assign n_pf = r_m_p + (r_m_sum >>> 4);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_t <= r_m_t;
            priority if (r_m_flt) begin
                r_o_p   <= baro_pkg::PRESSURE_MAX;
                r_o_flt <= 1'b1;
            end else if (n_pf[31]) begin
                r_o_p   <= '0;
                r_o_flt <= 1'b1;
            end else if (n_pf > $signed({14'b0, baro_pkg::PRESSURE_MAX})) begin
                r_o_p   <= baro_pkg::PRESSURE_MAX;
                r_o_flt <= 1'b1;
            end else begin
                r_o_p   <= n_pf[17:0];
                r_o_flt <= 1'b0;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_e_v   <= 1'b0;
            r_f_v   <= 1'b0;
            r_g_v   <= 1'b0;
            r_h_v   <= 1'b0;
            r_i_v   <= 1'b0;
            r_k_v   <= 1'b0;
            r_l_v   <= 1'b0;
            r_m_v   <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_a_v   <= i_in_valid;
            r_b_v   <= r_a_v;
            r_c_v   <= d1_vld;
            r_d_v   <= r_c_v;
            r_e_v   <= r_d_v;
            r_f_v   <= r_e_v;
            r_g_v   <= r_f_v;
            r_h_v   <= r_g_v;
            r_i_v   <= r_h_v;
            r_k_v   <= d2_vld;
            r_l_v   <= r_k_v;
            r_m_v   <= r_l_v;
            r_o_vld <= r_m_v;
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_temperature = r_o_t;
    assign o_pressure    = r_o_p;
    assign o_fault       = r_o_flt;

    // ------------------------------------------------------------ checks
    logic r_p_div_flt;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_div_flt <= r_i_flt || (r_i_b4 == '0);
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pressure)
            && $stable(o_temperature) && $stable(o_fault))
        else $error("stalled result changed");

    a_divzero_faults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_i_v && r_i_b4 == '0 |=> r_p_div_flt)
        else $error("zero pressure divisor without fault");

    a_sat_faults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pressure == '0 && !o_fault |-> $past(n_pf) == '0
            || !$past(en))
        else $error("pressure floor reached without fault");

endmodule
